// ===== rtl/tlnrf_pkg.sv =====
// Shared types and constants of the telnet receive filter.
package tlnrf_pkg;

  localparam logic [7:0] TN_IAC  = 8'hFF;
  localparam logic [7:0] TN_WILL = 8'hFB;
  localparam logic [7:0] TN_DO   = 8'hFD;
  localparam logic [7:0] TN_SGA  = 8'h03;
  localparam logic [7:0] TN_NUL  = 8'h00;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = 1;
  localparam int unsigned QCNT_W      = 2;

  // What the back end has to carry out for one accepted byte.
  typedef enum logic {
    ACT_DATA  = 1'b0,
    ACT_REPLY = 1'b1
  } action_e;

  typedef struct packed {
    action_e    action;
    logic [7:0] data;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  localparam logic DEST_RXQ = 1'b0;
  localparam logic DEST_TX  = 1'b1;

endpackage

// ===== rtl/telnet_receive_filter_unit.sv =====
// Top level of the telnet receive filter: front end, action queue and back end.
// Path: a byte that yields a result is written into the action queue and then taken
// into the output register of the back end, from which the result is shown.
// Throughput: one byte per cycle while the queue has room; a suppress-go-ahead reply
// sends three bytes; bytes that follow fill the two-entry queue, then the input stalls.
// Reset: asynchronous, active low; text mode, normal data phase, queue empty.
module telnet_receive_filter_unit import tlnrf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       rx_valid_i,
  output logic       rx_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       dest_o,
  output logic [7:0] out_byte_o,
  output logic       last_of_run_o
);

  q_status_t q_status;
  q_entry_t  push_entry, head;
  logic      push, pop;

  tlnrf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .rx_valid_i   (rx_valid_i),
    .rx_stall_o   (rx_stall_o),
    .rx_byte_i    (rx_byte_i),
    .q_status_i   (q_status),
    .push_o       (push),
    .push_entry_o (push_entry)
  );

  tlnrf_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .pop_i        (pop),
    .head_o       (head),
    .status_o     (q_status)
  );

  tlnrf_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .q_status_i    (q_status),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .dest_o        (dest_o),
    .out_byte_o    (out_byte_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

// ===== rtl/tlnrf_front.sv =====
// Front end: accepts received bytes, tracks the telnet parse state and queues actions.
module tlnrf_front import tlnrf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       rx_valid_i,
  output logic       rx_stall_o,
  input  logic [7:0] rx_byte_i,
  input  q_status_t  q_status_i,
  output logic       push_o,
  output q_entry_t   push_entry_o
);

  typedef enum logic [2:0] {
    PH_DATA  = 3'b001,
    PH_CMD   = 3'b010,
    PH_PARAM = 3'b100
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [7:0] cmd_q, cmd_d;
  logic       skip_q, skip_d;
  logic       binary_q, binary_d;
  logic       accept;

  assign rx_stall_o = q_status_i.full;
  assign accept     = rx_valid_i && !q_status_i.full;

  always_comb begin
    phase_d      = phase_q;
    cmd_d        = cmd_q;
    skip_d       = skip_q;
    binary_d     = binary_q;
    push_o       = 1'b0;
    push_entry_o = '{action: ACT_DATA, data: rx_byte_i};
    if (accept) begin
      if (binary_q) begin
        // A 255 straight after a passed 255 is the second half of an escape.
        if (skip_q && rx_byte_i == TN_IAC) begin
          skip_d = 1'b0;
        end else begin
          skip_d = (rx_byte_i == TN_IAC);
          push_o = 1'b1;
        end
      end else begin
        unique case (phase_q)
          PH_CMD: begin
            if (rx_byte_i == TN_IAC) begin
              push_o  = 1'b1;
              phase_d = PH_DATA;
            end else begin
              cmd_d   = rx_byte_i;
              phase_d = PH_PARAM;
            end
          end
          PH_PARAM: begin
            if (cmd_q == TN_DO && rx_byte_i == TN_SGA) begin
              push_o       = 1'b1;
              push_entry_o = '{action: ACT_REPLY, data: rx_byte_i};
            end
            phase_d = PH_DATA;
          end
          default: begin
            phase_d = PH_DATA;
            if (rx_byte_i == TN_IAC) begin
              phase_d = PH_CMD;
            end else if (rx_byte_i != TN_NUL) begin
              push_o = 1'b1;
            end
          end
        endcase
      end
    end
    if (cfg_we_i) begin
      binary_d = cfg_wdata_i;
      skip_d   = 1'b0;
      phase_d  = PH_DATA;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_DATA;
      cmd_q    <= '0;
      skip_q   <= 1'b0;
      binary_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      cmd_q    <= cmd_d;
      skip_q   <= skip_d;
      binary_q <= binary_d;
    end
  end

endmodule

// ===== rtl/tlnrf_queue.sv =====
// Short action queue between the front and back ends.
module tlnrf_queue import tlnrf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  q_entry_t  push_entry_i,
  input  logic      pop_i,
  output q_entry_t  head_o,
  output q_status_t status_o
);

  q_entry_t            mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]   count_q;
  logic                do_push, do_pop;

  assign status_o.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign status_o.empty = (count_q == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign head_o         = mem_q[rd_ptr_q];

  function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= ptr_next(wr_ptr_q);
      if (do_pop)  rd_ptr_q <= ptr_next(rd_ptr_q);
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue fill count beyond depth");

  a_no_lost_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !status_o.full)
    else $error("request pushed into a full queue");

endmodule

// ===== rtl/tlnrf_back.sv =====
// Back end: expands queued actions into result items behind an output register.
module tlnrf_back import tlnrf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  q_entry_t   head_i,
  input  q_status_t  q_status_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       dest_o,
  output logic [7:0] out_byte_o,
  output logic       last_of_run_o
);

  typedef enum logic [2:0] {
    RS_IDLE = 3'b001,
    RS_WILL = 3'b010,
    RS_SGA  = 3'b100
  } rep_e;

  rep_e       rep_q, rep_d;
  logic       valid_q, valid_d;
  logic       dest_q, dest_d;
  logic [7:0] byte_q, byte_d;
  logic       last_q, last_d;
  logic       advance;

  // The output register may be refilled when empty or when taken this cycle.
  assign advance = !valid_q || !out_stall_i;

  always_comb begin
    rep_d   = rep_q;
    valid_d = valid_q;
    dest_d  = dest_q;
    byte_d  = byte_q;
    last_d  = last_q;
    pop_o   = 1'b0;
    if (advance) begin
      valid_d = 1'b0;
      unique case (rep_q)
        RS_WILL: begin
          valid_d = 1'b1;
          dest_d  = DEST_TX;
          byte_d  = TN_WILL;
          last_d  = 1'b0;
          rep_d   = RS_SGA;
        end
        RS_SGA: begin
          valid_d = 1'b1;
          dest_d  = DEST_TX;
          byte_d  = TN_SGA;
          last_d  = 1'b1;
          rep_d   = RS_IDLE;
        end
        default: begin
          rep_d = RS_IDLE;
          if (!q_status_i.empty) begin
            pop_o   = 1'b1;
            valid_d = 1'b1;
            if (head_i.action == ACT_REPLY) begin
              dest_d = DEST_TX;
              byte_d = TN_IAC;
              last_d = 1'b0;
              rep_d  = RS_WILL;
            end else begin
              dest_d = DEST_RXQ;
              byte_d = head_i.data;
              last_d = 1'b1;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rep_q   <= RS_IDLE;
      valid_q <= 1'b0;
    end else begin
      rep_q   <= rep_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dest_q <= dest_d;
    byte_q <= byte_d;
    last_q <= last_d;
  end

  assign out_valid_o   = valid_q;
  assign dest_o        = dest_q;
  assign out_byte_o    = byte_q;
  assign last_of_run_o = last_q;

  a_reply_pending_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rep_q != RS_IDLE) |-> (valid_q && dest_q == DEST_TX && !last_q))
    else $error("reply in progress without a shown reply byte");

  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !last_q) |-> (rep_q != RS_IDLE))
    else $error("non-final result with nothing to follow");

endmodule

// ===== tb/telnet_receive_filter_unit_test.sv =====
// Self-checking testbench for the telnet receive filter, with a byte-level predictor.
module telnet_receive_filter_unit_test import tlnrf_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QUIET_CYCLES = 8;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned IDLE_LIMIT   = 2000;

  typedef enum logic [1:0] {
    PH_DATA  = 2'd0,
    PH_IAC   = 2'd1,
    PH_PARAM = 2'd2
  } parse_phase_e;

  typedef enum logic [1:0] {
    STALL_NONE   = 2'd0,
    STALL_RANDOM = 2'd1,
    STALL_PERIOD = 2'd2
  } stall_mode_e;

  typedef struct {
    logic       dest;
    logic [7:0] data;
    logic       last;
  } filtered_byte_t;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       cfg_we_i      = 1'b0;
  logic       cfg_wdata_i   = 1'b0;
  logic       rx_valid_i    = 1'b0;
  logic       rx_stall_o;
  logic [7:0] rx_byte_i     = 8'h00;
  logic       out_valid_o;
  logic       out_stall_i   = 1'b0;
  logic       dest_o;
  logic [7:0] out_byte_o;
  logic       last_of_run_o;

  // Predictor state, mirroring the block.
  logic         binary_en  = 1'b0;
  parse_phase_e phase      = PH_DATA;
  logic [7:0]   held_cmd   = 8'h00;
  logic         dup_iac    = 1'b0;

  filtered_byte_t pending_out[$];
  int unsigned    mismatches  = 0;
  int unsigned    idle_cycles = 0;
  int unsigned    burst_left  = 0;
  int unsigned    rx_sent     = 0;

  stall_mode_e stall_mode = STALL_NONE;
  logic [7:0]  stall_cnt  = 8'h00;

  telnet_receive_filter_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .rx_valid_i    (rx_valid_i),
    .rx_stall_o    (rx_stall_o),
    .rx_byte_i     (rx_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .dest_o        (dest_o),
    .out_byte_o    (out_byte_o),
    .last_of_run_o (last_of_run_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // The receiver picks a new stall behaviour at random whenever the low six counter bits are zero.
  always @(posedge clk_i) begin
    stall_cnt <= stall_cnt + 8'd1;
    if (stall_cnt[5:0] == 6'd0) begin
      stall_mode <= stall_mode_e'($urandom_range(0, 2));
    end
    case (stall_mode)
      STALL_NONE: begin
        out_stall_i <= 1'b0;
      end
      STALL_RANDOM: begin
        out_stall_i <= ($urandom_range(0, 2) == 0);
      end
      default: begin
        out_stall_i <= (stall_cnt[2:0] < 3'd3);
      end
    endcase
  end

  function automatic void add_result(input logic dest, input logic [7:0] data);
    filtered_byte_t entry;
    entry.dest = dest;
    entry.data = data;
    entry.last = 1'b0;
    pending_out.insert(pending_out.size(), entry);
  endfunction

  function automatic void filter_byte(input logic [7:0] c);
    int unsigned n;
    n = 0;
    if (binary_en) begin
      if (dup_iac && c == TN_IAC) begin
        dup_iac = 1'b0;
      end else begin
        dup_iac = (c == TN_IAC);
        add_result(DEST_RXQ, c);
        n++;
      end
    end else begin
      case (phase)
        PH_IAC: begin
          if (c == TN_IAC) begin
            add_result(DEST_RXQ, c);
            n++;
            phase = PH_DATA;
          end else begin
            held_cmd = c;
            phase = PH_PARAM;
          end
        end
        PH_PARAM: begin
          if (held_cmd == TN_DO && c == TN_SGA) begin
            add_result(DEST_TX, TN_IAC);
            add_result(DEST_TX, TN_WILL);
            add_result(DEST_TX, TN_SGA);
            n = n + 3;
          end
          phase = PH_DATA;
        end
        default: begin
          phase = (c == TN_IAC) ? PH_IAC : PH_DATA;
          if (c != TN_IAC && c != TN_NUL) begin
            add_result(DEST_RXQ, c);
            n++;
          end
        end
      endcase
    end
    if (n > 0) begin
      pending_out[pending_out.size() - 1].last = 1'b1;
    end
  endfunction

  // Handshakes are sampled at the falling edge, where everything has settled for the
  // coming rising edge. The request is predicted before the result is checked.
  always @(negedge clk_i) begin
    filtered_byte_t want;
    if (rst_ni) begin
      if ((rx_valid_i && !rx_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (rx_valid_i && !rx_stall_o) begin
        filter_byte(rx_byte_i);
      end
      if (out_valid_o && !out_stall_i) begin
        if (pending_out.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual dest=%0b byte=%02h last=%0b",
                   $time, dest_o, out_byte_o, last_of_run_o);
          mismatches++;
        end else begin
          want = pending_out.pop_front();
          if (dest_o !== want.dest) begin
            $display("%0t: dest mismatch: expected %0b, actual %0b",
                     $time, want.dest, dest_o);
            mismatches++;
          end
          if (out_byte_o !== want.data) begin
            $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                     $time, want.data, out_byte_o);
            mismatches++;
          end
          if (last_of_run_o !== want.last) begin
            $display("%0t: last_of_run mismatch: expected %0b, actual %0b",
                     $time, want.last, last_of_run_o);
            mismatches++;
          end
        end
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("telnet_receive_filter_unit_test: FAIL");
        $finish;
      end
    end
  end

  // Sends one byte, with the sender working in bursts separated by random gaps.
  task automatic send_rx(input logic [7:0] b);
    int unsigned gap;
    logic        stalled;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4);
      if (gap > 0) begin
        rx_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    rx_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do begin
      @(negedge clk_i);
      stalled = rx_stall_o;
      @(posedge clk_i);
    end while (stalled);
    rx_sent++;
  endtask

  // Bytes that yield nothing may still be in flight once every result has arrived.
  task automatic wait_quiet();
    rx_valid_i <= 1'b0;
    burst_left = 0;
    while (pending_out.size() != 0) @(posedge clk_i);
    repeat (QUIET_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_mode(input logic binary);
    wait_quiet();
    cfg_wdata_i <= binary;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    binary_en = binary;
    dup_iac   = 1'b0;
    phase     = PH_DATA;
  endtask

  task automatic send_text_sequence();
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        send_rx(8'($urandom_range(0, 254)));
      end
      3: begin
        send_rx(TN_IAC);
        send_rx(TN_IAC);
      end
      4: begin
        send_rx(TN_IAC);
        send_rx(TN_DO);
        send_rx(TN_SGA);
      end
      5: begin
        send_rx(TN_IAC);
        send_rx(8'($urandom_range(0, 254)));
        send_rx(8'($urandom_range(0, 255)));
      end
      6: begin
        send_rx(TN_IAC);
        send_rx(TN_DO);
        send_rx(8'($urandom_range(0, 255)));
      end
      7: begin
        send_rx(TN_NUL);
      end
      8: begin
        send_rx(8'($urandom_range(0, 255)));
      end
      default: begin
        // A sequence cut short, then whatever follows.
        send_rx(TN_IAC);
        if ($urandom_range(0, 1) == 0) begin
          send_rx(TN_DO);
        end
      end
    endcase
  endtask

  task automatic send_binary_byte();
    if ($urandom_range(0, 1) == 0) begin
      send_rx(TN_IAC);
    end else begin
      send_rx(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic test_text_directed();
    send_rx(TN_NUL);
    send_rx(8'h01);
    send_rx(8'h80);
    send_rx(8'h7F);
    send_rx(TN_IAC);
    send_rx(TN_IAC);
    send_rx(TN_IAC);
    send_rx(TN_DO);
    send_rx(TN_SGA);
    send_rx(TN_IAC);
    send_rx(TN_DO);
    send_rx(TN_IAC);
    send_rx(TN_IAC);
    send_rx(TN_WILL);
    send_rx(TN_SGA);
    send_rx(8'hFE);
  endtask

  task automatic test_mode_write_clears_parse();
    send_rx(TN_IAC);
    send_rx(TN_DO);
    write_mode(1'b0);
    // The parse phase is back to normal data, so this is plain data.
    send_rx(TN_SGA);
  endtask

  task automatic test_binary_directed();
    write_mode(1'b1);
    send_rx(TN_IAC);
    send_rx(TN_IAC);
    send_rx(TN_IAC);
    send_rx(TN_NUL);
    send_rx(TN_IAC);
    write_mode(1'b1);
    send_rx(TN_IAC);
    send_rx(8'h41);
  endtask

  task automatic test_random_text();
    int unsigned stop_at;
    stop_at = rx_sent + 45;
    write_mode(1'b0);
    while (rx_sent < stop_at) send_text_sequence();
  endtask

  task automatic test_random_binary();
    int unsigned stop_at;
    stop_at = rx_sent + 30;
    write_mode(1'b1);
    while (rx_sent < stop_at) send_binary_byte();
  endtask

  task automatic test_random_mode_changes();
    logic binary;
    repeat (4) begin
      binary = 1'($urandom_range(0, 1));
      write_mode(binary);
      repeat (5) begin
        if (binary) begin
          send_binary_byte();
        end else begin
          send_text_sequence();
        end
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_text_directed();
    test_mode_write_clears_parse();
    test_binary_directed();
    test_random_text();
    test_random_binary();
    test_random_mode_changes();

    rx_valid_i <= 1'b0;
    while (pending_out.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("telnet_receive_filter_unit_test: PASS");
    end else begin
      $display("telnet_receive_filter_unit_test: FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/tlnrf_pkg.sv
rtl/tlnrf_front.sv
rtl/tlnrf_queue.sv
rtl/tlnrf_back.sv
rtl/telnet_receive_filter_unit.sv
tb/telnet_receive_filter_unit_test.sv
